// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the sprite atlas block.
// Each macro expects signals named clock and reset in the calling scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SACU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sprite atlas cell check failed");

// Next-cycle implication, disabled while reset is high.
`define SACU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sprite atlas cell check failed");

`endif

// ===== sv/sacu_pkg.sv =====
// ---------------------------------------------------------------------------
// Sprite atlas cell package
// Widths, register indexes, sequencer states and helpers shared by the
// sprite atlas cell block, its interfaces and its checker.
// ---------------------------------------------------------------------------
package sacu_pkg;

   // Default upper bound on the animation frame count.
   localparam int FRAME_LIMIT_DEF = 4096;

   // Field widths.
   localparam int PERIOD_W   = 32;
   localparam int COUNT_W    = 13;
   localparam int EDGE_W     = 17;
   localparam int TIME_W     = 32;
   localparam int CELL_W     = 12;
   localparam int COORD_W    = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Shared divider geometry.
   localparam int REM_W = PERIOD_W + 1;
   localparam int DQ_W  = EDGE_W + 1;
   localparam int CNT_W = 5;
   localparam int PROD_W = TIME_W + COUNT_W + 1;
   localparam int SUM_W  = 48;

   // Division lengths in steps.
   localparam logic [CNT_W-1:0] FRAME_STEPS = CNT_W'(COUNT_W);
   localparam logic [CNT_W-1:0] EDGE_STEPS  = CNT_W'(DQ_W);

   // Inward margin of 0.01 in 16 fraction bits, and the coordinate range.
   localparam logic signed [SUM_W-1:0] EDGE_MARGIN = 48'sd655;
   localparam logic signed [SUM_W-1:0] COORD_MIN   = -48'sd131072;
   localparam logic signed [SUM_W-1:0] COORD_MAX   = 48'sd131071;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANIM_PERIOD   = 3'd0,
      CSR_MAX_FRAMES    = 3'd1,
      CSR_FRAMES_ACROSS = 3'd2,
      CSR_FRAMES_DOWN   = 3'd3,
      CSR_ATLAS_U_MIN   = 3'd4,
      CSR_ATLAS_V_MIN   = 3'd5,
      CSR_ATLAS_U_MAX   = 3'd6,
      CSR_ATLAS_V_MAX   = 3'd7
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_T,
      ST_CHK_T,
      ST_DIV_T,
      ST_FRAME,
      ST_LOAD_W,
      ST_DIV_W,
      ST_LOAD_H,
      ST_DIV_H,
      ST_LOAD_C,
      ST_DIV_C,
      ST_MUL_U,
      ST_MUL_V,
      ST_FIN,
      ST_OUT
   } state_type;

   // Control of the shared divider.
   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   // Saturate a wide signed coordinate to the output range.
   function automatic logic signed [COORD_W-1:0] clamp_coord(
      input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      c = v;
      if (v < COORD_MIN) begin
         c = COORD_MIN;
      end
      if (v > COORD_MAX) begin
         c = COORD_MAX;
      end
      return c[COORD_W-1:0];
   endfunction

endpackage

// ===== sv/sacu_req_if.sv =====
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one animation lookup transaction.
// ---------------------------------------------------------------------------
interface sacu_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 command;
   logic signed [sacu_pkg::TIME_W-1:0]   anim_time;
   logic        [sacu_pkg::CELL_W-1:0]   cell_number;

   modport source (output valid, command, anim_time, cell_number, input ready);
   modport sink   (input valid, command, anim_time, cell_number, output ready);
endinterface

// ===== sv/sacu_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the frame number and its texture rectangle.
// ---------------------------------------------------------------------------
interface sacu_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 before_start;
   logic        [sacu_pkg::CELL_W-1:0]   frame_number;
   logic signed [sacu_pkg::COORD_W-1:0]  u_left;
   logic signed [sacu_pkg::COORD_W-1:0]  u_right;
   logic signed [sacu_pkg::COORD_W-1:0]  v_top;
   logic signed [sacu_pkg::COORD_W-1:0]  v_bottom;

   modport source (output valid, before_start, frame_number, u_left, u_right,
                   v_top, v_bottom, input ready);
   modport sink   (input valid, before_start, frame_number, u_left, u_right,
                   v_top, v_bottom, output ready);
endinterface

// ===== sv/sacu_csr_if.sv =====
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ---------------------------------------------------------------------------
interface sacu_csr_if;
   logic                               valid;
   logic                               ready;
   logic [sacu_pkg::CSR_IDX_W-1:0]     index;
   logic [sacu_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/sprite_atlas_cell_uv.sv =====
// ---------------------------------------------------------------------------
// Sprite atlas cell coordinates
// Maps an animation time or a direct frame number to the inset texture
// rectangle of that frame in a sprite atlas, using one shared divider and
// one shared multiplier under a small sequencer.
// ---------------------------------------------------------------------------
//
//   channel   direction   handshake      contents
//   req_bus   in          valid/ready    command, anim_time, cell_number
//   rsp_bus   out         valid/ready    before_start, frame, rectangle edges
//   csr_bus   in          valid/ready    register index, write data
//
// A time lookup runs the time division before the extent and frame divisions;
// it skips that division when the product saturates the frame or the period
// is zero, a direct frame lookup skips it too, and a negative time goes
// straight to the response; the next request can be taken in the cycle after
// the response transaction. The serial divisions (time by period, extent by
// columns and rows, frame by columns) run in the one-bit-per-cycle divider.
// Reset is synchronous and active high; it restores the register defaults.
// A stalled response holds the block; configuration writes are always taken.
//
module sprite_atlas_cell_uv #(
   parameter int FRAME_LIMIT = sacu_pkg::FRAME_LIMIT_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sacu_req_if.sink      req_bus,
   sacu_rsp_if.source    rsp_bus,
   sacu_csr_if.sink      csr_bus
);

   // Configuration registers.
   logic [sacu_pkg::PERIOD_W-1:0] anim_period_ff;
   logic [sacu_pkg::COUNT_W-1:0]  max_frames_ff;
   logic [sacu_pkg::COUNT_W-1:0]  frames_across_ff;
   logic [sacu_pkg::COUNT_W-1:0]  frames_down_ff;
   logic [sacu_pkg::EDGE_W-1:0]   atlas_u_min_ff;
   logic [sacu_pkg::EDGE_W-1:0]   atlas_v_min_ff;
   logic [sacu_pkg::EDGE_W-1:0]   atlas_u_max_ff;
   logic [sacu_pkg::EDGE_W-1:0]   atlas_v_max_ff;

   // Sequencer.
   sacu_pkg::state_type           state_ff, state_in;
   logic [sacu_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   // Working registers.
   logic [sacu_pkg::TIME_W-2:0]         time_ff;
   logic                                neg_ff;
   logic signed [sacu_pkg::COORD_W-1:0] cw_ff;
   logic signed [sacu_pkg::COORD_W-1:0] ch_ff;
   logic signed [sacu_pkg::PROD_W-1:0]  prod_ff;

   // Result registers.
   logic                                before_ff;
   logic [sacu_pkg::COUNT_W-1:0]        frame_ff;
   logic signed [sacu_pkg::COORD_W-1:0] u_left_ff;
   logic signed [sacu_pkg::COORD_W-1:0] u_right_ff;
   logic signed [sacu_pkg::COORD_W-1:0] v_top_ff;
   logic signed [sacu_pkg::COORD_W-1:0] v_bottom_ff;

   // Effective counts and handshake strobes.
   logic [sacu_pkg::COUNT_W-1:0]  nframes;
   logic [sacu_pkg::COUNT_W-1:0]  across;
   logic [sacu_pkg::COUNT_W-1:0]  down;
   logic                          req_take;
   logic                          rsp_take;
   logic                          cnt_last;

   // Divider and multiplier connections.
   sacu_pkg::div_ctrl_type              div_ctrl;
   logic [sacu_pkg::REM_W-1:0]          div_load_rem;
   logic [sacu_pkg::DQ_W-1:0]           div_load_dq;
   logic [sacu_pkg::PERIOD_W-1:0]       div_divisor;
   logic [sacu_pkg::REM_W-1:0]          div_rem;
   logic [sacu_pkg::DQ_W-1:0]           div_dq;
   logic signed [sacu_pkg::TIME_W-1:0]  mul_a;
   logic signed [sacu_pkg::COUNT_W:0]   mul_b;
   logic signed [sacu_pkg::PROD_W-1:0]  prod_full;

   // Datapath helpers.
   logic [sacu_pkg::TIME_W-2:0]         prod_hi;
   logic                                period_sat;
   logic [sacu_pkg::COUNT_W-1:0]        quot_frame;
   logic signed [sacu_pkg::DQ_W-1:0]    ext_diff;
   logic [sacu_pkg::DQ_W-1:0]           ext_mag;
   logic signed [sacu_pkg::DQ_W:0]      quot_signed;
   logic signed [sacu_pkg::DQ_W:0]      floor_q;
   logic signed [sacu_pkg::SUM_W-1:0]   corner;
   logic signed [sacu_pkg::SUM_W-1:0]   cell_ext;

   // Out-of-range frame counts fold into 1..FRAME_LIMIT, zero sizes into 1.
   always_comb begin
      nframes = max_frames_ff;
      if (max_frames_ff == '0) begin
         nframes = sacu_pkg::COUNT_W'(1);
      end else if (32'(max_frames_ff) > 32'(FRAME_LIMIT)) begin
         nframes = sacu_pkg::COUNT_W'(FRAME_LIMIT);
      end
      across = (frames_across_ff == '0) ? sacu_pkg::COUNT_W'(1) : frames_across_ff;
      down   = (frames_down_ff == '0) ? sacu_pkg::COUNT_W'(1) : frames_down_ff;
   end

   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_take = rsp_bus.valid && rsp_bus.ready;
   assign cnt_last = (cnt_ff == sacu_pkg::CNT_W'(1));

   // Configuration writes are taken in any state.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         anim_period_ff   <= sacu_pkg::PERIOD_W'(65536);
         max_frames_ff    <= sacu_pkg::COUNT_W'(1);
         frames_across_ff <= sacu_pkg::COUNT_W'(1);
         frames_down_ff   <= sacu_pkg::COUNT_W'(1);
         atlas_u_min_ff   <= '0;
         atlas_v_min_ff   <= '0;
         atlas_u_max_ff   <= sacu_pkg::EDGE_W'(65536);
         atlas_v_max_ff   <= sacu_pkg::EDGE_W'(65536);
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (sacu_pkg::csr_index_type'(csr_bus.index))
            sacu_pkg::CSR_ANIM_PERIOD:   anim_period_ff   <= csr_bus.data;
            sacu_pkg::CSR_MAX_FRAMES:
               max_frames_ff <= csr_bus.data[sacu_pkg::COUNT_W-1:0];
            sacu_pkg::CSR_FRAMES_ACROSS:
               frames_across_ff <= csr_bus.data[sacu_pkg::COUNT_W-1:0];
            sacu_pkg::CSR_FRAMES_DOWN:
               frames_down_ff <= csr_bus.data[sacu_pkg::COUNT_W-1:0];
            sacu_pkg::CSR_ATLAS_U_MIN:
               atlas_u_min_ff <= csr_bus.data[sacu_pkg::EDGE_W-1:0];
            sacu_pkg::CSR_ATLAS_V_MIN:
               atlas_v_min_ff <= csr_bus.data[sacu_pkg::EDGE_W-1:0];
            sacu_pkg::CSR_ATLAS_U_MAX:
               atlas_u_max_ff <= csr_bus.data[sacu_pkg::EDGE_W-1:0];
            sacu_pkg::CSR_ATLAS_V_MAX:
               atlas_v_max_ff <= csr_bus.data[sacu_pkg::EDGE_W-1:0];
            default: ;
         endcase
      end
   end

   // Time-mode saturation check: a quotient of 2^COUNT_W or more, or a
   // zero period, pins the frame to the last one.
   assign prod_hi    = prod_ff[sacu_pkg::PROD_W-3:sacu_pkg::COUNT_W];
   assign period_sat = (anim_period_ff == '0) || ({1'b0, prod_hi} >= anim_period_ff);
   assign quot_frame = div_dq[sacu_pkg::COUNT_W-1:0];

   // Signed extent in the direction being loaded, and its magnitude.
   always_comb begin
      if (state_ff == sacu_pkg::ST_LOAD_W) begin
         ext_diff = $signed({1'b0, atlas_u_max_ff}) - $signed({1'b0, atlas_u_min_ff});
      end else begin
         ext_diff = $signed({1'b0, atlas_v_max_ff}) - $signed({1'b0, atlas_v_min_ff});
      end
      ext_mag = ext_diff[sacu_pkg::DQ_W-1] ? sacu_pkg::DQ_W'(-ext_diff)
                                           : sacu_pkg::DQ_W'(ext_diff);
   end

   // Floor correction of the finished magnitude division.
   always_comb begin
      quot_signed = $signed({1'b0, div_dq});
      if (neg_ff) begin
         floor_q = -quot_signed - (sacu_pkg::DQ_W+1)'(|div_rem);
      end else begin
         floor_q = quot_signed;
      end
   end

   // Edge sums: the base corner, and the cell size being used.
   always_comb begin
      if (state_ff == sacu_pkg::ST_MUL_V) begin
         corner   = $signed({31'b0, atlas_u_min_ff}) + sacu_pkg::SUM_W'(prod_ff);
         cell_ext = sacu_pkg::SUM_W'(cw_ff);
      end else begin
         corner   = $signed({31'b0, atlas_v_min_ff}) + sacu_pkg::SUM_W'(prod_ff);
         cell_ext = sacu_pkg::SUM_W'(ch_ff);
      end
   end

   // Shared multiplier.
   assign prod_full = mul_a * mul_b;

   // Shared divider.
   sacu_div u_div (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .load_rem (div_load_rem),
      .load_dq  (div_load_dq),
      .divisor  (div_divisor),
      .rem      (div_rem),
      .dq       (div_dq)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sacu_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_bus.command) begin
                  state_in = sacu_pkg::ST_LOAD_W;
               end else if (req_bus.anim_time[sacu_pkg::TIME_W-1]) begin
                  state_in = sacu_pkg::ST_OUT;
               end else begin
                  state_in = sacu_pkg::ST_MUL_T;
               end
            end
         end
         sacu_pkg::ST_MUL_T: state_in = sacu_pkg::ST_CHK_T;
         sacu_pkg::ST_CHK_T:
            state_in = period_sat ? sacu_pkg::ST_LOAD_W : sacu_pkg::ST_DIV_T;
         sacu_pkg::ST_DIV_T: if (cnt_last) state_in = sacu_pkg::ST_FRAME;
         sacu_pkg::ST_FRAME: state_in = sacu_pkg::ST_LOAD_W;
         sacu_pkg::ST_LOAD_W: state_in = sacu_pkg::ST_DIV_W;
         sacu_pkg::ST_DIV_W: if (cnt_last) state_in = sacu_pkg::ST_LOAD_H;
         sacu_pkg::ST_LOAD_H: state_in = sacu_pkg::ST_DIV_H;
         sacu_pkg::ST_DIV_H: if (cnt_last) state_in = sacu_pkg::ST_LOAD_C;
         sacu_pkg::ST_LOAD_C: state_in = sacu_pkg::ST_DIV_C;
         sacu_pkg::ST_DIV_C: if (cnt_last) state_in = sacu_pkg::ST_MUL_U;
         sacu_pkg::ST_MUL_U: state_in = sacu_pkg::ST_MUL_V;
         sacu_pkg::ST_MUL_V: state_in = sacu_pkg::ST_FIN;
         sacu_pkg::ST_FIN: state_in = sacu_pkg::ST_OUT;
         sacu_pkg::ST_OUT: if (rsp_take) state_in = sacu_pkg::ST_IDLE;
         default: state_in = sacu_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshakes, divider control and operand selection.
   always_comb begin
      req_bus.ready  = (state_ff == sacu_pkg::ST_IDLE);
      rsp_bus.valid  = (state_ff == sacu_pkg::ST_OUT);
      div_ctrl       = '0;
      div_load_rem   = '0;
      div_load_dq    = {ext_mag};
      div_divisor    = sacu_pkg::PERIOD_W'(across);
      mul_a          = $signed({1'b0, time_ff});
      mul_b          = $signed({1'b0, nframes});
      cnt_in         = cnt_ff;
      case (state_ff)
         sacu_pkg::ST_CHK_T: begin
            div_ctrl.load = !period_sat;
            div_load_rem  = sacu_pkg::REM_W'(prod_hi);
            div_load_dq   = {prod_ff[sacu_pkg::COUNT_W-1:0],
                             (sacu_pkg::DQ_W-sacu_pkg::COUNT_W)'(0)};
            div_divisor   = anim_period_ff;
            cnt_in        = sacu_pkg::FRAME_STEPS;
         end
         sacu_pkg::ST_DIV_T: begin
            div_ctrl.step = 1'b1;
            div_divisor   = anim_period_ff;
            cnt_in        = cnt_ff - sacu_pkg::CNT_W'(1);
         end
         sacu_pkg::ST_LOAD_W: begin
            div_ctrl.load = 1'b1;
            cnt_in        = sacu_pkg::EDGE_STEPS;
         end
         sacu_pkg::ST_LOAD_H: begin
            div_ctrl.load = 1'b1;
            div_divisor   = sacu_pkg::PERIOD_W'(down);
            cnt_in        = sacu_pkg::EDGE_STEPS;
         end
         sacu_pkg::ST_DIV_H: begin
            div_ctrl.step = 1'b1;
            div_divisor   = sacu_pkg::PERIOD_W'(down);
            cnt_in        = cnt_ff - sacu_pkg::CNT_W'(1);
         end
         sacu_pkg::ST_LOAD_C: begin
            div_ctrl.load = 1'b1;
            div_load_dq   = {frame_ff, (sacu_pkg::DQ_W-sacu_pkg::COUNT_W)'(0)};
            cnt_in        = sacu_pkg::FRAME_STEPS;
         end
         sacu_pkg::ST_DIV_W, sacu_pkg::ST_DIV_C: begin
            div_ctrl.step = 1'b1;
            cnt_in        = cnt_ff - sacu_pkg::CNT_W'(1);
         end
         sacu_pkg::ST_MUL_U: begin
            // Column is the remainder of the frame division.
            mul_a = sacu_pkg::TIME_W'(cw_ff);
            mul_b = $signed({1'b0, div_rem[sacu_pkg::COUNT_W-1:0]});
         end
         sacu_pkg::ST_MUL_V: begin
            // Row is the quotient of the frame division.
            mul_a = sacu_pkg::TIME_W'(ch_ff);
            mul_b = $signed({1'b0, div_dq[sacu_pkg::COUNT_W-1:0]});
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacu_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         sacu_pkg::ST_IDLE: begin
            time_ff     <= req_bus.anim_time[sacu_pkg::TIME_W-2:0];
            before_ff   <= !req_bus.command && req_bus.anim_time[sacu_pkg::TIME_W-1];
            frame_ff    <= req_bus.command ? {1'b0, req_bus.cell_number} : '0;
            u_left_ff   <= '0;
            u_right_ff  <= '0;
            v_top_ff    <= '0;
            v_bottom_ff <= '0;
         end
         sacu_pkg::ST_MUL_T: prod_ff <= prod_full;
         sacu_pkg::ST_CHK_T: begin
            if (period_sat) begin
               frame_ff <= nframes - sacu_pkg::COUNT_W'(1);
            end
         end
         sacu_pkg::ST_FRAME: begin
            frame_ff <= (quot_frame >= nframes) ? nframes - sacu_pkg::COUNT_W'(1)
                                                : quot_frame;
         end
         sacu_pkg::ST_LOAD_W: neg_ff <= ext_diff[sacu_pkg::DQ_W-1];
         sacu_pkg::ST_LOAD_H: begin
            cw_ff  <= floor_q[sacu_pkg::COORD_W-1:0];
            neg_ff <= ext_diff[sacu_pkg::DQ_W-1];
         end
         sacu_pkg::ST_LOAD_C: ch_ff <= floor_q[sacu_pkg::COORD_W-1:0];
         sacu_pkg::ST_MUL_U: prod_ff <= prod_full;
         sacu_pkg::ST_MUL_V: begin
            u_left_ff  <= sacu_pkg::clamp_coord(corner + sacu_pkg::EDGE_MARGIN);
            u_right_ff <= sacu_pkg::clamp_coord(corner + cell_ext - sacu_pkg::EDGE_MARGIN);
            prod_ff    <= prod_full;
         end
         sacu_pkg::ST_FIN: begin
            v_top_ff    <= sacu_pkg::clamp_coord(corner + sacu_pkg::EDGE_MARGIN);
            v_bottom_ff <= sacu_pkg::clamp_coord(corner + cell_ext - sacu_pkg::EDGE_MARGIN);
         end
         default: ;
      endcase
   end

   // Response payload.
   assign rsp_bus.before_start = before_ff;
   assign rsp_bus.frame_number = frame_ff[sacu_pkg::CELL_W-1:0];
   assign rsp_bus.u_left       = u_left_ff;
   assign rsp_bus.u_right      = u_right_ff;
   assign rsp_bus.v_top        = v_top_ff;
   assign rsp_bus.v_bottom     = v_bottom_ff;

endmodule

// ===== sv/sacu_div.sv =====
// ---------------------------------------------------------------------------
// Shared restoring divider
// One quotient bit per step. The dividend enters left-aligned in the
// dividend/quotient register and quotient bits fill it from the right.
// ---------------------------------------------------------------------------
module sacu_div (
   input  logic                              clock,
   input  sacu_pkg::div_ctrl_type            ctrl,
   input  logic [sacu_pkg::REM_W-1:0]        load_rem,
   input  logic [sacu_pkg::DQ_W-1:0]         load_dq,
   input  logic [sacu_pkg::PERIOD_W-1:0]     divisor,
   output logic [sacu_pkg::REM_W-1:0]        rem,
   output logic [sacu_pkg::DQ_W-1:0]         dq
);

   logic [sacu_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [sacu_pkg::DQ_W-1:0]  dq_ff, dq_in;
   logic [sacu_pkg::REM_W-1:0] shifted;
   logic [sacu_pkg::REM_W:0]   trial;

   // Trial subtraction of the divisor from the shifted partial remainder.
   always_comb begin
      shifted = {rem_ff[sacu_pkg::REM_W-2:0], dq_ff[sacu_pkg::DQ_W-1]};
      trial   = {1'b0, shifted} - {2'b00, divisor};
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      if (ctrl.load) begin
         rem_in = load_rem;
         dq_in  = load_dq;
      end else if (ctrl.step) begin
         if (!trial[sacu_pkg::REM_W]) begin
            rem_in = trial[sacu_pkg::REM_W-1:0];
            dq_in  = {dq_ff[sacu_pkg::DQ_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            dq_in  = {dq_ff[sacu_pkg::DQ_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign rem = rem_ff;
   assign dq  = dq_ff;

endmodule

// ===== sv/sacu_checker.sv =====
// ---------------------------------------------------------------------------
// Sprite atlas cell checker
// Port-level checks of the sprite atlas cell block, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sacu_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 before_start,
   input logic        [sacu_pkg::CELL_W-1:0]   frame_number,
   input logic signed [sacu_pkg::COORD_W-1:0]  u_left,
   input logic signed [sacu_pkg::COORD_W-1:0]  u_right,
   input logic signed [sacu_pkg::COORD_W-1:0]  v_top,
   input logic signed [sacu_pkg::COORD_W-1:0]  v_bottom
);

   // The block works on one transaction at a time.
   `SACU_ASSERT_NOW(a_one_at_a_time, rsp_valid, !req_ready)

   // A taken request closes the request side.
   `SACU_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

   // A finished response reopens the request side at once.
   `SACU_ASSERT_NEXT(a_idle_after_rsp, rsp_valid && rsp_ready, req_ready && !rsp_valid)

   // A response before the animation starts carries no frame or edges.
   `SACU_ASSERT_NOW(a_before_start_zero, rsp_valid && before_start,
      frame_number == '0 && u_left == '0 && u_right == '0 && v_top == '0 && v_bottom == '0)

   // A stalled response stays offered.
   `SACU_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind sprite_atlas_cell_uv sacu_checker u_sacu_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .before_start (rsp_bus.before_start),
   .frame_number (rsp_bus.frame_number),
   .u_left       (rsp_bus.u_left),
   .u_right      (rsp_bus.u_right),
   .v_top        (rsp_bus.v_top),
   .v_bottom     (rsp_bus.v_bottom)
);

// ===== test/tb_sprite_atlas_cell_uv.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sprite atlas cell lookup testbench
// Sends time and direct-frame lookups through the request channel and checks
// every response against an in-bench model of the frame choice and the inset
// cell rectangle. Register settings change only while no lookup is
// outstanding. Both channels idle at random, except in one back-to-back
// stretch.
// ---------------------------------------------------------------------------
module tb_sprite_atlas_cell_uv;

   localparam int     FRAME_CAP        = sacu_pkg::FRAME_LIMIT_DEF;
   localparam logic   CMD_FROM_TIME    = 1'b0;
   localparam logic   CMD_DIRECT_FRAME = 1'b1;
   localparam longint UV_MARGIN        = 655;
   localparam longint UV_LOW           = -131072;
   localparam longint UV_HIGH          = 131071;
   localparam int     DRAIN_CYCLES     = 80;

   // One expected response.
   typedef struct packed {
      logic                          before_start;
      logic [sacu_pkg::CELL_W-1:0]   frame_number;
      logic [sacu_pkg::COORD_W-1:0]  u_left;
      logic [sacu_pkg::COORD_W-1:0]  u_right;
      logic [sacu_pkg::COORD_W-1:0]  v_top;
      logic [sacu_pkg::COORD_W-1:0]  v_bottom;
   } uv_rect_type;

   logic clock;
   logic reset;

   sacu_req_if req_bus ();
   sacu_rsp_if rsp_bus ();
   sacu_csr_if csr_bus ();

   sprite_atlas_cell_uv #(
      .FRAME_LIMIT (FRAME_CAP)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Local copy of the register file.
   logic [sacu_pkg::PERIOD_W-1:0] atlas_period;
   logic [sacu_pkg::COUNT_W-1:0]  atlas_frames;
   logic [sacu_pkg::COUNT_W-1:0]  atlas_across;
   logic [sacu_pkg::COUNT_W-1:0]  atlas_down;
   logic [sacu_pkg::EDGE_W-1:0]   atlas_u_min;
   logic [sacu_pkg::EDGE_W-1:0]   atlas_v_min;
   logic [sacu_pkg::EDGE_W-1:0]   atlas_u_max;
   logic [sacu_pkg::EDGE_W-1:0]   atlas_v_max;

   uv_rect_type rect_queue[$];
   bit          idle_enable;
   int          err_count;
   int          lookups_sent;
   int          rects_checked;
   int          settings_used;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net against a hung handshake.
   initial begin
      #10ms;
      $display("Timeout with %0d responses still outstanding.", rect_queue.size());
      $display("tb_sprite_atlas_cell_uv NOT OK");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   function automatic longint at_least_one(longint v);
      return (v == 0) ? 1 : v;
   endfunction

   // Division rounded toward minus infinity; the divisor is always positive.
   function automatic longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic logic [sacu_pkg::COORD_W-1:0] saturate_uv(longint v);
      longint c;
      c = v;
      if (c < UV_LOW) begin
         c = UV_LOW;
      end
      if (c > UV_HIGH) begin
         c = UV_HIGH;
      end
      return c[sacu_pkg::COORD_W-1:0];
   endfunction

   function automatic longint frame_count();
      longint n;
      n = at_least_one(longint'(atlas_frames));
      if (n > FRAME_CAP) begin
         n = FRAME_CAP;
      end
      return n;
   endfunction

   function automatic uv_rect_type predict_rect(logic cmd, logic [sacu_pkg::TIME_W-1:0] t,
                                                logic [sacu_pkg::CELL_W-1:0] cell_num);
      uv_rect_type r;
      longint      nfr, acr, dwn, frm, cw, ch, ux, vy;
      r   = '0;
      nfr = frame_count();
      acr = at_least_one(longint'(atlas_across));
      dwn = at_least_one(longint'(atlas_down));

      // A negative time gives an all-zero rectangle with the flag set.
      if (cmd == CMD_FROM_TIME && t[sacu_pkg::TIME_W-1]) begin
         r.before_start = 1'b1;
         return r;
      end

      if (cmd == CMD_DIRECT_FRAME) begin
         frm = longint'(cell_num);
      end else if (atlas_period == 0) begin
         frm = nfr - 1;
      end else begin
         frm = (longint'(t) * nfr) / longint'(atlas_period);
         if (frm >= nfr) begin
            frm = nfr - 1;
         end
      end

      cw = floor_quot(longint'(atlas_u_max) - longint'(atlas_u_min), acr);
      ch = floor_quot(longint'(atlas_v_max) - longint'(atlas_v_min), dwn);
      ux = longint'(atlas_u_min) + (frm % acr) * cw;
      vy = longint'(atlas_v_min) + (frm / acr) * ch;

      r.frame_number = frm[sacu_pkg::CELL_W-1:0];
      r.u_left       = saturate_uv(ux + UV_MARGIN);
      r.u_right      = saturate_uv(ux + cw - UV_MARGIN);
      r.v_top        = saturate_uv(vy + UV_MARGIN);
      r.v_bottom     = saturate_uv(vy + ch - UV_MARGIN);
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   // Ready drops at random, with a chance of 17 in 100, while idling is enabled.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !(idle_enable && $urandom_range(99) < 17);
      end
   end

   function automatic void report_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   // Compare each response transaction with the oldest expectation.
   always @(posedge clock) begin : rect_check
      uv_rect_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rect_queue.size() == 0) begin
            $error("Response with no lookup outstanding, frame %0d.",
                   rsp_bus.frame_number);
            err_count++;
         end else begin
            want = rect_queue.pop_front();
            rects_checked++;
            report_field("before_start", 32'(want.before_start),
                         32'(rsp_bus.before_start));
            report_field("frame_number", 32'(want.frame_number),
                         32'(rsp_bus.frame_number));
            report_field("u_left", 32'($signed(want.u_left)), 32'(rsp_bus.u_left));
            report_field("u_right", 32'($signed(want.u_right)), 32'(rsp_bus.u_right));
            report_field("v_top", 32'($signed(want.v_top)), 32'(rsp_bus.v_top));
            report_field("v_bottom", 32'($signed(want.v_bottom)), 32'(rsp_bus.v_bottom));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Request and register drivers; every task starts and ends at a falling edge
   // -------------------------------------------------------------------------

   // Offer one lookup; valid stays high afterward so the next one can follow
   // without a gap.
   task automatic send_lookup(logic cmd, logic [sacu_pkg::TIME_W-1:0] t,
                              logic [sacu_pkg::CELL_W-1:0] cell_num);
      int gap;
      gap = 0;
      if (idle_enable && $urandom_range(99) < 17) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.anim_time   <= t;
      req_bus.cell_number <= cell_num;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      rect_queue.push_back(predict_rect(cmd, t, cell_num));
      lookups_sent++;
      @(negedge clock);
   endtask

   // Withdraw the request and wait until every response has arrived.
   task automatic finish_lookups();
      req_bus.valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (rect_queue.size() != 0);
   endtask

   task automatic write_reg(sacu_pkg::csr_index_type idx,
                            logic [sacu_pkg::CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      case (idx)
         sacu_pkg::CSR_ANIM_PERIOD:   atlas_period = data;
         sacu_pkg::CSR_MAX_FRAMES:    atlas_frames = data[sacu_pkg::COUNT_W-1:0];
         sacu_pkg::CSR_FRAMES_ACROSS: atlas_across = data[sacu_pkg::COUNT_W-1:0];
         sacu_pkg::CSR_FRAMES_DOWN:   atlas_down   = data[sacu_pkg::COUNT_W-1:0];
         sacu_pkg::CSR_ATLAS_U_MIN:   atlas_u_min  = data[sacu_pkg::EDGE_W-1:0];
         sacu_pkg::CSR_ATLAS_V_MIN:   atlas_v_min  = data[sacu_pkg::EDGE_W-1:0];
         sacu_pkg::CSR_ATLAS_U_MAX:   atlas_u_max  = data[sacu_pkg::EDGE_W-1:0];
         sacu_pkg::CSR_ATLAS_V_MAX:   atlas_v_max  = data[sacu_pkg::EDGE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Rewrite the whole register file once the block has gone quiet.
   task automatic set_atlas(logic [31:0] period, logic [31:0] frames, logic [31:0] across,
                            logic [31:0] down, logic [31:0] u_min, logic [31:0] v_min,
                            logic [31:0] u_max, logic [31:0] v_max);
      finish_lookups();
      write_reg(sacu_pkg::CSR_ANIM_PERIOD, period);
      write_reg(sacu_pkg::CSR_MAX_FRAMES, frames);
      write_reg(sacu_pkg::CSR_FRAMES_ACROSS, across);
      write_reg(sacu_pkg::CSR_FRAMES_DOWN, down);
      write_reg(sacu_pkg::CSR_ATLAS_U_MIN, u_min);
      write_reg(sacu_pkg::CSR_ATLAS_V_MIN, v_min);
      write_reg(sacu_pkg::CSR_ATLAS_U_MAX, u_max);
      write_reg(sacu_pkg::CSR_ATLAS_V_MAX, v_max);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // -------------------------------------------------------------------------
   // Random choices
   // -------------------------------------------------------------------------

   function automatic logic [31:0] pick_count();
      case ($urandom_range(9))
         0:       return 0;
         1:       return 1;
         2:       return FRAME_CAP;
         3:       return $urandom_range(FRAME_CAP + 1, 8191);
         4, 5, 6: return $urandom_range(2, 8);
         default: return $urandom_range(9, 64);
      endcase
   endfunction

   function automatic logic [31:0] pick_edge();
      case ($urandom_range(5))
         0:       return 0;
         1:       return 65536;
         2:       return $urandom_range(65537, 131071);
         default: return $urandom_range(0, 65536);
      endcase
   endfunction

   task automatic pick_random_atlas();
      logic [31:0] period;
      case ($urandom_range(7))
         0:       period = 0;
         1:       period = 32'hFFFF_FFFF;
         2:       period = $urandom_range(1, 16);
         3, 4, 5: period = $urandom_range(32'h0001_0000, 32'h0040_0000);
         default: period = $urandom;
      endcase
      set_atlas(period, pick_count(), pick_count(), pick_count(),
                pick_edge(), pick_edge(), pick_edge(), pick_edge());
   endtask

   // Times cluster inside the animation and around frame boundaries.
   function automatic logic [sacu_pkg::TIME_W-1:0] pick_time();
      longint per, nfr, k, t;
      per = longint'(atlas_period);
      nfr = frame_count();
      case ($urandom_range(9))
         0, 1: t = longint'({1'b1, 31'($urandom)});
         2:    t = longint'($urandom);
         3, 4, 5: begin
            if (per == 0 || per > 32'h7FFF_FFFF) begin
               t = longint'($urandom_range(0, 32'h7FFF_FFFF));
            end else begin
               t = longint'($urandom_range(0, 32'(per)));
            end
         end
         6, 7: begin
            k = longint'($urandom_range(0, 32'(nfr)));
            t = (k * per) / nfr + int'($urandom_range(0, 2)) - 1;
            if (t < 0) begin
               t = 0;
            end
            if (t > 32'h7FFF_FFFF) begin
               t = 32'h7FFF_FFFF;
            end
         end
         8: t = longint'($urandom_range(0, 255));
         default: begin
            case ($urandom_range(3))
               0:       t = 0;
               1:       t = 32'h7FFF_FFFF;
               2:       t = 32'h8000_0000;
               default: t = 32'hFFFF_FFFF;
            endcase
         end
      endcase
      return t[sacu_pkg::TIME_W-1:0];
   endfunction

   task automatic send_random_lookup();
      logic [sacu_pkg::CELL_W-1:0] cell_num;
      if ($urandom_range(1) == 0) begin
         cell_num = sacu_pkg::CELL_W'($urandom_range(0, 32'(frame_count() - 1)));
      end else begin
         cell_num = sacu_pkg::CELL_W'($urandom_range(0, 4095));
      end
      send_lookup(1'($urandom_range(1)), pick_time(), cell_num);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Register defaults: one full-atlas frame, one-unit period.
   task automatic test_reset_defaults();
      send_lookup(CMD_FROM_TIME, 32'h0000_0000, 12'h000);
      send_lookup(CMD_FROM_TIME, 32'h7FFF_FFFF, 12'hFFF);
      send_lookup(CMD_FROM_TIME, 32'hFFFF_FFFF, 12'h000);
      send_lookup(CMD_FROM_TIME, 32'h8000_0000, 12'h5A5);
      send_lookup(CMD_DIRECT_FRAME, 32'h1234_5678, 12'h000);
      // Row 4095 of a full-height cell pushes the vertical edges past the top.
      send_lookup(CMD_DIRECT_FRAME, 32'h0000_0000, 12'hFFF);
   endtask

   // Ten frames over a 4 x 3 atlas, probed at frame boundaries and past the end.
   task automatic test_time_frames();
      set_atlas(32'h0064_0000, 10, 4, 3, 32'h1000, 32'h0800, 32'hF000, 32'hE000);
      send_lookup(CMD_FROM_TIME, 32'h0000_0000, 12'h000);
      send_lookup(CMD_FROM_TIME, 32'h0009_FFFF, 12'h000);
      send_lookup(CMD_FROM_TIME, 32'h000A_0000, 12'h000);
      send_lookup(CMD_FROM_TIME, 32'h0063_0000, 12'h000);
      send_lookup(CMD_FROM_TIME, 32'h0064_0000, 12'h000);
      // Direct frames beyond the animation and beyond the atlas rows.
      send_lookup(CMD_DIRECT_FRAME, 32'hFFFF_FFFF, 12'd11);
      send_lookup(CMD_DIRECT_FRAME, 32'h0000_0000, 12'hFFF);
   endtask

   // Zero period, out-of-range frame counts, zero columns and rows.
   task automatic test_degenerate_counts();
      set_atlas(0, 0, 0, 0, 0, 0, 65536, 65536);
      send_lookup(CMD_FROM_TIME, 32'h0000_0005, 12'h000);
      send_lookup(CMD_DIRECT_FRAME, 32'h0000_0000, 12'd3);
      set_atlas(0, 8191, 1, 1, 0, 0, 65536, 65536);
      send_lookup(CMD_FROM_TIME, 32'h0000_0001, 12'h000);
      set_atlas(32'hFFFF_FFFF, FRAME_CAP + 1, FRAME_CAP, FRAME_CAP, 0, 0, 65536, 65536);
      send_lookup(CMD_FROM_TIME, 32'h7FFF_FFFF, 12'h000);
      send_lookup(CMD_DIRECT_FRAME, 32'h0000_0000, 12'hFFF);
   endtask

   // Max edges below min edges; cell sizes are negative and round downward.
   task automatic test_reversed_edges();
      set_atlas(32'h0001_0000, 16, 3, 7, 65536, 131071, 0, 1);
      send_lookup(CMD_DIRECT_FRAME, 32'h0000_0000, 12'd0);
      send_lookup(CMD_DIRECT_FRAME, 32'h0000_0000, 12'd2);
      send_lookup(CMD_DIRECT_FRAME, 32'h0000_0000, 12'hFFF);
      send_lookup(CMD_FROM_TIME, 32'h0000_8000, 12'h000);
   endtask

   // Several random register settings, each with a stream of lookups.
   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         pick_random_atlas();
         for (int n = 0; n < 85; n++) begin
            // Let the pipeline empty once in the middle of the first setting.
            if (phase == 0 && n == 40) begin
               finish_lookups();
            end
            send_random_lookup();
         end
      end
   endtask

   // A stretch with neither side idling.
   task automatic test_back_to_back();
      pick_random_atlas();
      idle_enable = 1'b0;
      repeat (90) send_random_lookup();
      finish_lookups();
      idle_enable = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.command     = CMD_FROM_TIME;
      req_bus.anim_time   = '0;
      req_bus.cell_number = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = sacu_pkg::CSR_ANIM_PERIOD;
      csr_bus.data        = '0;
      idle_enable         = 1'b1;
      err_count           = 0;
      lookups_sent        = 0;
      rects_checked       = 0;
      settings_used       = 1;
      atlas_period        = 32'h0001_0000;
      atlas_frames        = 1;
      atlas_across        = 1;
      atlas_down          = 1;
      atlas_u_min         = 0;
      atlas_v_min         = 0;
      atlas_u_max         = 65536;
      atlas_v_max         = 65536;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_time_frames();
      test_degenerate_counts();
      test_reversed_edges();
      test_random_settings();
      test_back_to_back();

      finish_lookups();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d lookups over %0d register settings, time and direct frames,",
               lookups_sent, settings_used);
      $display("%0d responses checked, %0d mismatches.", rects_checked, err_count);
      if (err_count == 0) begin
         $display("tb_sprite_atlas_cell_uv OK");
      end else begin
         $display("tb_sprite_atlas_cell_uv NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sacu_pkg.sv
sv/sacu_req_if.sv
sv/sacu_rsp_if.sv
sv/sacu_csr_if.sv
sv/sacu_div.sv
sv/sprite_atlas_cell_uv.sv
sv/sacu_checker.sv
test/tb_sprite_atlas_cell_uv.sv
